[rtl/lcsd_pkg.sv]
`default_nettype none
package lcsd_pkg;

  localparam int LEVEL_W   = 16;
  localparam int FACTOR_W  = 14;
  localparam int TIME_W    = 32;
  localparam int RAND_W    = 32;
  localparam int DROP_W    = 14;
  localparam int DUR_W     = 24;
  localparam int INTV_W    = 28;

  localparam int DIV_DVD_W = 40;
  localparam int DIV_DVS_W = 29;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd40;

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 16'd65535;
  localparam logic [FACTOR_W-1:0] UNITY_BP    = 14'd10000;
  localparam logic [12:0]         HALF_UNITY  = 13'd5000;
  localparam logic [15:0]         ENV_FULL    = 16'd32768;
  localparam logic [15:0]         ENV_HALF    = 16'd16384;
  localparam logic [27:0]         RECIP_625   = 28'd219902326;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_DROP_MIN = 3'd1;
  localparam logic [2:0] REG_DROP_MAX = 3'd2;
  localparam logic [2:0] REG_DUR_MIN  = 3'd3;
  localparam logic [2:0] REG_DUR_MAX  = 3'd4;
  localparam logic [2:0] REG_INT_MIN  = 3'd5;
  localparam logic [2:0] REG_INT_MAX  = 3'd6;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_SCALE = 2'd1,
    KIND_FRAME = 2'd2
  } lcsd_kind_t;

  typedef struct packed {
    logic              enable;
    logic [DROP_W-1:0] drop_min;
    logic [DROP_W-1:0] drop_max;
    logic [DUR_W-1:0]  dur_min;
    logic [DUR_W-1:0]  dur_max;
    logic [INTV_W-1:0] int_min;
    logic [INTV_W-1:0] int_max;
  } lcsd_cfg_t;

  typedef struct packed {
    lcsd_kind_t         kind;
    logic [TIME_W-1:0]  now;
    logic [RAND_W-1:0]  r_drop;
    logic [RAND_W-1:0]  r_dur;
    logic [RAND_W-1:0]  r_int;
    logic [LEVEL_W-1:0] level;
  } lcsd_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } lcsd_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
    logic [DIV_DVS_W-1:0] rem;
  } lcsd_div_rsp_t;

endpackage
`default_nettype wire

[rtl/lcsd_front.sv]
`default_nettype none
module lcsd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_enable,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic                  in_frame,
  input  wire logic [31:0]           in_now,
  input  wire logic [31:0]           in_r_drop,
  input  wire logic [31:0]           in_r_dur,
  input  wire logic [31:0]           in_r_int,
  input  wire logic [15:0]           in_level,
  output logic                       item_valid,
  output lcsd_pkg::lcsd_item_t       item,
  input  wire logic                  item_pop
);

  lcsd_pkg::lcsd_item_t q_r [2];
  lcsd_pkg::lcsd_item_t push_item;
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           count_r;
  logic                 push;

  always_comb begin
    push_item.now    = in_now;
    push_item.r_drop = in_r_drop;
    push_item.r_dur  = in_r_dur;
    push_item.r_int  = in_r_int;
    push_item.level  = in_level;
    if (!cfg_enable) begin
      push_item.kind = lcsd_pkg::KIND_PASS;
    end else if (in_frame) begin
      push_item.kind = lcsd_pkg::KIND_FRAME;
    end else begin
      push_item.kind = lcsd_pkg::KIND_SCALE;
    end
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (item_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, item_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/lcsd_div.sv]
`default_nettype none
module lcsd_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lcsd_pkg::lcsd_div_req_t req,
  output lcsd_pkg::lcsd_div_rsp_t      rsp
);

  logic [lcsd_pkg::DIV_DVD_W-1:0] quo_r;
  logic [lcsd_pkg::DIV_DVS_W-1:0] rem_r;
  logic [lcsd_pkg::DIV_DVS_W-1:0] dvs_r;
  logic [lcsd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [lcsd_pkg::DIV_DVS_W:0]   trial;
  logic [lcsd_pkg::DIV_DVS_W:0]   diff;
  logic                           fits;

  assign trial = {rem_r, quo_r[lcsd_pkg::DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[lcsd_pkg::DIV_DVD_W-2:0], fits};
      rem_r <= fits ? diff[lcsd_pkg::DIV_DVS_W-1:0] : trial[lcsd_pkg::DIV_DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == lcsd_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= lcsd_pkg::DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - lcsd_pkg::DIV_CNT_W'(1);
        if (cnt_r == lcsd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

[rtl/lcsd_back.sv]
`default_nettype none
module lcsd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lcsd_pkg::lcsd_cfg_t  cfg,
  input  wire logic                 cfg_clr,
  input  wire logic                 item_valid,
  input  wire lcsd_pkg::lcsd_item_t item,
  output logic                      item_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_level,
  output logic                      out_active,
  output logic [13:0]               out_factor
);

  typedef enum logic [10:0] {
    S_IDLE         = 11'b00000000001,
    S_DRAW_START   = 11'b00000000010,
    S_DRAW_WAIT    = 11'b00000000100,
    S_EXPIRE       = 11'b00000001000,
    S_FACTOR_START = 11'b00000010000,
    S_FACTOR_WAIT  = 11'b00000100000,
    S_FACTOR_MUL   = 11'b00001000000,
    S_FACTOR_FIN   = 11'b00010000000,
    S_SCALE_MUL    = 11'b00100000000,
    S_SCALE_DIV    = 11'b01000000000,
    S_OUT          = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    DRAW_DROP = 2'd0,
    DRAW_DUR  = 2'd1,
    DRAW_INT  = 2'd2
  } draw_t;

  state_t               state_r, state_nxt;
  draw_t                draw_sel_r, draw_sel_nxt;
  lcsd_pkg::lcsd_item_t cur_r, cur_nxt;
  logic                 active_r, active_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [23:0]          len_r, len_nxt;
  logic [13:0]          drop_r, drop_nxt;
  logic [31:0]          next_r, next_nxt;
  logic [13:0]          factor_r, factor_nxt;
  logic [15:0]          env_r, env_nxt;
  logic [30:0]          prod_r, prod_nxt;
  logic [15:0]          res_level_r, res_level_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_level_r, out_level_nxt;
  logic                 out_active_r, out_active_nxt;
  logic [13:0]          out_factor_r, out_factor_nxt;

  lcsd_pkg::lcsd_div_req_t div_req;
  lcsd_pkg::lcsd_div_rsp_t div_rsp;

  logic [27:0] draw_lo;
  logic [27:0] draw_hi;
  logic [31:0] draw_rand;
  logic [28:0] draw_span;
  logic [28:0] draw_sum;
  logic [27:0] draw_val;
  logic        draw_store;
  logic [31:0] fire_diff;
  logic [31:0] elapsed;
  logic [23:0] elapsed_c;
  logic [15:0] progress;
  logic [15:0] env_tail;
  logic [30:0] dropped_sum;
  logic [15:0] dropped;
  logic [26:0] scale_y;
  logic [54:0] scale_q;
  logic [17:0] scaled;
  logic        out_load;

  lcsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    case (draw_sel_r)
      DRAW_DROP: begin
        draw_lo   = {14'd0, cfg.drop_min};
        draw_hi   = {14'd0, cfg.drop_max};
        draw_rand = cur_r.r_drop;
      end
      DRAW_DUR: begin
        draw_lo   = {4'd0, cfg.dur_min};
        draw_hi   = {4'd0, cfg.dur_max};
        draw_rand = cur_r.r_dur;
      end
      default: begin
        draw_lo   = cfg.int_min;
        draw_hi   = cfg.int_max;
        draw_rand = cur_r.r_int;
      end
    endcase
  end

  assign draw_span   = {1'b0, draw_hi} - {1'b0, draw_lo} + 29'd1;
  assign draw_sum    = {1'b0, draw_lo} + div_rsp.rem;
  assign fire_diff   = item.now - next_r;
  assign elapsed     = cur_r.now - start_r;
  assign elapsed_c   = (elapsed > {8'd0, len_r}) ? len_r : elapsed[23:0];
  assign progress    = (div_rsp.quot[15:0] > lcsd_pkg::ENV_FULL) ? lcsd_pkg::ENV_FULL
                                                                 : div_rsp.quot[15:0];
  assign env_tail    = lcsd_pkg::ENV_FULL - progress;
  assign dropped_sum = prod_r + {15'd0, lcsd_pkg::ENV_HALF};
  assign dropped     = dropped_sum[30:15];
  assign scale_y     = prod_r[30:4];
  assign scale_q     = {28'd0, scale_y} * {27'd0, lcsd_pkg::RECIP_625};
  assign scaled      = scale_q[54:37];

  always_comb begin
    state_nxt      = state_r;
    draw_sel_nxt   = draw_sel_r;
    cur_nxt        = cur_r;
    active_nxt     = active_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    drop_nxt       = drop_r;
    next_nxt       = next_r;
    factor_nxt     = factor_r;
    env_nxt        = env_r;
    prod_nxt       = prod_r;
    res_level_nxt  = res_level_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_level_nxt  = out_level_r;
    out_active_nxt = out_active_r;
    out_factor_nxt = out_factor_r;
    item_pop       = 1'b0;
    out_load       = 1'b0;
    draw_store     = 1'b0;
    draw_val       = draw_lo;
    div_req.start    = 1'b0;
    div_req.dividend = {8'd0, draw_rand};
    div_req.divisor  = draw_span;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          cur_nxt  = item;
          case (item.kind)
            lcsd_pkg::KIND_PASS: begin
              active_nxt    = 1'b0;
              factor_nxt    = lcsd_pkg::UNITY_BP;
              res_level_nxt = item.level;
              state_nxt     = S_OUT;
            end
            lcsd_pkg::KIND_FRAME: begin
              if (!active_r && !fire_diff[31]) begin
                start_nxt    = item.now;
                active_nxt   = 1'b1;
                draw_sel_nxt = DRAW_DROP;
                state_nxt    = S_DRAW_START;
              end else begin
                state_nxt = S_EXPIRE;
              end
            end
            default: begin
              state_nxt = S_SCALE_MUL;
            end
          endcase
        end
      end
      S_DRAW_START: begin
        if (draw_hi <= draw_lo) begin
          draw_store = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DRAW_WAIT;
        end
      end
      S_DRAW_WAIT: begin
        if (div_rsp.done) begin
          draw_val   = draw_sum[27:0];
          draw_store = 1'b1;
        end
      end
      S_EXPIRE: begin
        if (active_r && (len_r != 24'd0) && (elapsed >= {8'd0, len_r})) begin
          active_nxt = 1'b0;
        end
        state_nxt = S_FACTOR_START;
      end
      S_FACTOR_START: begin
        if (!active_r || (len_r == 24'd0)) begin
          factor_nxt = lcsd_pkg::UNITY_BP;
          state_nxt  = S_SCALE_MUL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, elapsed_c, 15'd0};
          div_req.divisor  = {5'd0, len_r};
          state_nxt        = S_FACTOR_WAIT;
        end
      end
      S_FACTOR_WAIT: begin
        if (div_rsp.done) begin
          env_nxt   = (progress <= lcsd_pkg::ENV_HALF) ? {progress[14:0], 1'b0}
                                                       : {env_tail[14:0], 1'b0};
          state_nxt = S_FACTOR_MUL;
        end
      end
      S_FACTOR_MUL: begin
        prod_nxt  = {1'b0, {16'd0, drop_r} * {14'd0, env_r}};
        state_nxt = S_FACTOR_FIN;
      end
      S_FACTOR_FIN: begin
        if (dropped >= {2'd0, lcsd_pkg::UNITY_BP}) begin
          factor_nxt = '0;
        end else begin
          factor_nxt = lcsd_pkg::UNITY_BP - dropped[13:0];
        end
        state_nxt = S_SCALE_MUL;
      end
      S_SCALE_MUL: begin
        prod_nxt  = {1'b0, {14'd0, cur_r.level} * {16'd0, factor_r}}
                  + {18'd0, lcsd_pkg::HALF_UNITY};
        state_nxt = S_SCALE_DIV;
      end
      S_SCALE_DIV: begin
        res_level_nxt = (scaled > {2'd0, lcsd_pkg::LEVEL_MAX}) ? lcsd_pkg::LEVEL_MAX
                                                               : scaled[15:0];
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_level_nxt  = res_level_r;
          out_active_nxt = active_r;
          out_factor_nxt = factor_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (draw_store) begin
      case (draw_sel_r)
        DRAW_DROP: drop_nxt = draw_val[13:0];
        DRAW_DUR:  len_nxt  = draw_val[23:0];
        default:   next_nxt = cur_r.now + {4'd0, draw_val};
      endcase
      if (draw_sel_r == DRAW_INT) begin
        state_nxt = S_EXPIRE;
      end else begin
        draw_sel_nxt = draw_t'(draw_sel_r + 2'd1);
        state_nxt    = S_DRAW_START;
      end
    end

    if (cfg_clr) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    env_r        <= env_nxt;
    prod_r       <= prod_nxt;
    res_level_r  <= res_level_nxt;
    out_level_r  <= out_level_nxt;
    out_active_r <= out_active_nxt;
    out_factor_r <= out_factor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      draw_sel_r  <= DRAW_DROP;
      active_r    <= 1'b0;
      start_r     <= '0;
      len_r       <= '0;
      drop_r      <= '0;
      next_r      <= '0;
      factor_r    <= lcsd_pkg::UNITY_BP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      draw_sel_r  <= draw_sel_nxt;
      active_r    <= active_nxt;
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      drop_r      <= drop_nxt;
      next_r      <= next_nxt;
      factor_r    <= factor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_level  = out_level_r;
  assign out_active = out_active_r;
  assign out_factor = out_factor_r;

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    factor_r <= lcsd_pkg::UNITY_BP)
    else $error("scale factor above unity");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> (state_r == S_IDLE) && item_valid)
    else $error("queue popped outside idle");

  a_pass_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !cfg.enable) |=> (out_factor_r == lcsd_pkg::UNITY_BP) && !out_active_r)
    else $error("disabled transaction not passed at unity");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DRAW_WAIT) || (state_r == S_FACTOR_WAIT))
    else $error("divider result with no waiting step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

[rtl/led_cloud_shadow_dimmer.sv]
// LED cloud shadow dimmer.
// in_*: one transaction per LED channel level; in_tuser marks the first
// channel of a frame, in_tdata carries the time stamp, three random words and
// the level. out_*: one transaction per input, in order, with the dimmed level,
// the scale factor and the cloud flag. cfg_*: APB-style register port, one
// register per word; pready is always high and every write completes at once.
// A two-deep queue sits behind in_tready, and a result register sits on the
// output, so input keeps flowing while a finished result waits.
// Ordinary items pass the back end through scale multiply, scale divide and
// output (straight to output with the overlay disabled). A frame-start item
// first checks expiry and, with a cloud running, waits on an envelope division
// in the shared one-bit-per-cycle divider; a cloud that arms first adds three
// modulo draws in the same divider (drop, duration, interval), each done
// without a division when max <= min.
// Reset: overlay disabled, registers at their defaults, no cloud, unity factor,
// next fire time zero so the first enabled frame with a time stamp below 2^31 arms a cloud.
// A stalled receiver holds the result register; once the queue fills,
// in_tready drops until results drain.
`default_nettype none
module led_cloud_shadow_dimmer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // now_ms, rand_drop, rand_duration, rand_interval, level_in
  input  wire logic         in_tuser,   // frame_start
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // level_out, factor_out, zero fill
  output logic              out_tuser,  // cloud_active
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  lcsd_pkg::lcsd_cfg_t  cfg_r;
  lcsd_pkg::lcsd_item_t item;
  logic                 item_valid;
  logic                 item_pop;
  logic                 cfg_wr;
  logic                 cfg_clr;
  logic [2:0]           cfg_idx;
  logic [15:0]          out_level;
  logic [13:0]          out_factor;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_clr    = cfg_wr && (cfg_idx == lcsd_pkg::REG_ENABLE) && !cfg_pwdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b0;
      cfg_r.drop_min <= 14'd3000;
      cfg_r.drop_max <= 14'd6000;
      cfg_r.dur_min  <= 24'd30000;
      cfg_r.dur_max  <= 24'd300000;
      cfg_r.int_min  <= 28'd300000;
      cfg_r.int_max  <= 28'd1800000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcsd_pkg::REG_ENABLE:   cfg_r.enable   <= cfg_pwdata[0];
        lcsd_pkg::REG_DROP_MIN: cfg_r.drop_min <= cfg_pwdata[13:0];
        lcsd_pkg::REG_DROP_MAX: cfg_r.drop_max <= cfg_pwdata[13:0];
        lcsd_pkg::REG_DUR_MIN:  cfg_r.dur_min  <= cfg_pwdata[23:0];
        lcsd_pkg::REG_DUR_MAX:  cfg_r.dur_max  <= cfg_pwdata[23:0];
        lcsd_pkg::REG_INT_MIN:  cfg_r.int_min  <= cfg_pwdata[27:0];
        lcsd_pkg::REG_INT_MAX:  cfg_r.int_max  <= cfg_pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lcsd_pkg::REG_ENABLE:   cfg_prdata = {31'd0, cfg_r.enable};
      lcsd_pkg::REG_DROP_MIN: cfg_prdata = {18'd0, cfg_r.drop_min};
      lcsd_pkg::REG_DROP_MAX: cfg_prdata = {18'd0, cfg_r.drop_max};
      lcsd_pkg::REG_DUR_MIN:  cfg_prdata = {8'd0, cfg_r.dur_min};
      lcsd_pkg::REG_DUR_MAX:  cfg_prdata = {8'd0, cfg_r.dur_max};
      lcsd_pkg::REG_INT_MIN:  cfg_prdata = {4'd0, cfg_r.int_min};
      lcsd_pkg::REG_INT_MAX:  cfg_prdata = {4'd0, cfg_r.int_max};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  lcsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_enable (cfg_r.enable),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_frame   (in_tuser),
    .in_now     (in_tdata[31:0]),
    .in_r_drop  (in_tdata[63:32]),
    .in_r_dur   (in_tdata[95:64]),
    .in_r_int   (in_tdata[127:96]),
    .in_level   (in_tdata[143:128]),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  lcsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_clr    (cfg_clr),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_level  (out_level),
    .out_active (out_tuser),
    .out_factor (out_factor)
  );

  assign out_tdata = {2'd0, out_factor, out_level};

endmodule
`default_nettype wire

[tb/led_cloud_shadow_dimmer_checker.sv]
`timescale 1ns / 100ps
module led_cloud_shadow_dimmer_checker
  import lcsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,   // now_ms, rand_drop, rand_duration, rand_interval, level_in
  input  logic         in_tuser,   // frame_start
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,  // level_out, factor_out, zero fill
  input  logic         out_tuser,  // cloud_active
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending_results
);

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                active;
    logic [FACTOR_W-1:0] factor;
  } dim_result_t;

  dim_result_t dimmed_q[$];

  logic                overlay_en;
  logic [DROP_W-1:0]   drop_lo, drop_hi;
  logic [DUR_W-1:0]    dur_lo, dur_hi;
  logic [INTV_W-1:0]   intv_lo, intv_hi;

  logic                cloud_on;
  logic [TIME_W-1:0]   cloud_t0;
  logic [DUR_W-1:0]    cloud_len;
  logic [DROP_W-1:0]   cloud_depth;
  logic [TIME_W-1:0]   fire_at;
  logic [FACTOR_W-1:0] held_factor;

  function automatic logic [31:0] draw_span(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [31:0] r);
    logic [63:0] span;
    if (hi <= lo) return lo;
    span = 64'(hi) - 64'(lo) + 64'd1;
    return lo + 32'(64'(r) % span);
  endfunction

  function automatic logic [FACTOR_W-1:0] envelope_factor(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] progress;
    logic [63:0] env;
    logic [63:0] dropped;
    if (!cloud_on || cloud_len == '0) return UNITY_BP;
    elapsed = now - cloud_t0;
    if (elapsed > 32'(cloud_len)) elapsed = 32'(cloud_len);
    progress = {17'd0, elapsed, 15'd0} / 64'(cloud_len);
    if (progress > 64'(ENV_FULL)) progress = 64'(ENV_FULL);
    env = (progress <= 64'(ENV_HALF)) ? (progress << 1) : ((64'(ENV_FULL) - progress) << 1);
    dropped = (64'(cloud_depth) * env + 64'(ENV_HALF)) >> 15;
    if (dropped >= 64'(UNITY_BP)) return '0;
    return UNITY_BP - FACTOR_W'(dropped);
  endfunction

  task automatic predict_dimmed(input logic frame, input logic [31:0] now,
                                input logic [31:0] r_drop, input logic [31:0] r_dur,
                                input logic [31:0] r_int, input logic [15:0] level,
                                output dim_result_t res);
    logic [31:0] since_fire;
    logic [31:0] age;
    logic [63:0] scaled;
    if (!overlay_en) begin
      cloud_on = 1'b0;
      held_factor = UNITY_BP;
      res.level = level;
      res.active = 1'b0;
      res.factor = UNITY_BP;
    end else begin
      if (frame) begin
        since_fire = now - fire_at;
        if (!cloud_on && !since_fire[31]) begin
          cloud_depth = DROP_W'(draw_span(32'(drop_lo), 32'(drop_hi), r_drop));
          cloud_len = DUR_W'(draw_span(32'(dur_lo), 32'(dur_hi), r_dur));
          cloud_t0 = now;
          cloud_on = 1'b1;
          fire_at = now + draw_span(32'(intv_lo), 32'(intv_hi), r_int);
        end
        age = now - cloud_t0;
        if (cloud_on && cloud_len != '0 && age >= 32'(cloud_len)) cloud_on = 1'b0;
        held_factor = envelope_factor(now);
      end
      scaled = (64'(level) * 64'(held_factor) + 64'(HALF_UNITY)) / 64'(UNITY_BP);
      if (scaled > 64'(LEVEL_MAX)) scaled = 64'(LEVEL_MAX);
      res.level = scaled[LEVEL_W-1:0];
      res.active = cloud_on;
      res.factor = held_factor;
    end
  endtask

  always @(posedge clk) begin
    dim_result_t want;
    dim_result_t got;
    if (!rst_n) begin
      overlay_en = 1'b0;
      drop_lo = 14'd3000;
      drop_hi = 14'd6000;
      dur_lo = 24'd30000;
      dur_hi = 24'd300000;
      intv_lo = 28'd300000;
      intv_hi = 28'd1800000;
      cloud_on = 1'b0;
      cloud_t0 = '0;
      cloud_len = '0;
      cloud_depth = '0;
      fire_at = '0;
      held_factor = UNITY_BP;
      dimmed_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_ENABLE: begin
            overlay_en = cfg_pwdata[0];
            if (!cfg_pwdata[0]) cloud_on = 1'b0;
          end
          REG_DROP_MIN: drop_lo = cfg_pwdata[DROP_W-1:0];
          REG_DROP_MAX: drop_hi = cfg_pwdata[DROP_W-1:0];
          REG_DUR_MIN:  dur_lo = cfg_pwdata[DUR_W-1:0];
          REG_DUR_MAX:  dur_hi = cfg_pwdata[DUR_W-1:0];
          REG_INT_MIN:  intv_lo = cfg_pwdata[INTV_W-1:0];
          REG_INT_MAX:  intv_hi = cfg_pwdata[INTV_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_dimmed(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                       in_tdata[127:96], in_tdata[143:128], want);
        dimmed_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[15:0];
        got.factor = out_tdata[29:16];
        got.active = out_tuser;
        if (dimmed_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected transaction: level %0d active %0b factor %0d",
                     got.level, got.active, got.factor);
          fail_count++;
        end else begin
          want = dimmed_q.pop_front();
          if (got.level !== want.level || got.active !== want.active ||
              got.factor !== want.factor) begin
            if (fail_count < 10)
              $display("mismatch: expected level %0d active %0b factor %0d, got level %0d active %0b factor %0d",
                       want.level, want.active, want.factor,
                       got.level, got.active, got.factor);
            fail_count++;
          end
        end
      end
    end
    pending_results = dimmed_q.size();
  end

endmodule

[tb/led_cloud_shadow_dimmer_tb.sv]
`timescale 1ns / 100ps
module led_cloud_shadow_dimmer_tb;
  import lcsd_pkg::*;

  localparam logic [2:0]  REG_NONE = 3'd7;
  localparam logic [31:0] T_BASE   = 32'h4000_0000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;   // now_ms, rand_drop, rand_duration, rand_interval, level_in
  logic         in_tuser = 1'b0; // frame_start
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;       // level_out, factor_out, zero fill
  logic         out_tuser;       // cloud_active
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int          fail_count;
  int          pending_results;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] uptime_ms;

  led_cloud_shadow_dimmer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  led_cloud_shadow_dimmer_checker dim_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hold off for a long stretch whenever one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #30_000_000;
    $display("led_cloud_shadow_dimmer regression: fail");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_pace(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_cloud_cfg(input logic [31:0] drop_lo, input logic [31:0] drop_hi,
                               input logic [31:0] dur_lo, input logic [31:0] dur_hi,
                               input logic [31:0] int_lo, input logic [31:0] int_hi);
    cfg_write(REG_DROP_MIN, drop_lo);
    cfg_write(REG_DROP_MAX, drop_hi);
    cfg_write(REG_DUR_MIN, dur_lo);
    cfg_write(REG_DUR_MAX, dur_hi);
    cfg_write(REG_INT_MIN, int_lo);
    cfg_write(REG_INT_MAX, int_hi);
  endtask

  task automatic send_item(input logic frame, input logic [31:0] now,
                           input logic [31:0] r_drop, input logic [31:0] r_dur,
                           input logic [31:0] r_int, input logic [15:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = frame;
    in_tdata = {level, r_int, r_dur, r_drop, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic frame_at(input logic [31:0] now, input logic [31:0] r, input logic [15:0] level);
    send_item(1'b1, now, r, r, r, level);
  endtask

  // frames of channel levels on an advancing clock, with a few frames stamped in the past
  task automatic cloud_frames(input int n_items, input int step_lo, input int step_hi);
    int sent;
    int chans;
    bit held;
    bit paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!held && sent >= n_items / 3) begin
        held = 1'b1;
        hold_req++;
      end
      if (!paused && sent >= 2 * n_items / 3) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 6) begin
        send_item(1'b1, uptime_ms - $urandom_range(3000, 1), rand_word(), rand_word(),
                  rand_word(), rand_level());
      end else begin
        send_item(1'b1, uptime_ms, rand_word(), rand_word(), rand_word(), rand_level());
        chans = $urandom_range(5, 0);
        repeat (chans) send_item(1'b0, $urandom, $urandom, $urandom, $urandom, rand_level());
        sent += chans;
      end
      sent++;
      uptime_ms += $urandom_range(step_hi, step_lo);
    end
    drain();
  endtask

  task automatic next_phase(input int k);
    set_pace(k);
    uptime_ms += $urandom_range(32'h4000_0000, 32'h1000_0000);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // overlay off after reset: levels pass untouched
    send_item(1'b1, '0, '0, '0, '0, 16'hFFFF);
    send_item(1'b0, '1, '1, '1, '1, 16'h0000);
    drain();

    // defaults: first frame arms, then peak, rise, expiry and the wait for the next fire
    cfg_write(REG_ENABLE, 32'd1);
    frame_at(32'd0, '0, 16'hFFFF);
    send_item(1'b0, 32'd5, '1, '1, '1, 16'hFFFF);
    send_item(1'b0, 32'd5, '1, '1, '1, 16'h0001);
    send_item(1'b0, 32'd5, '1, '1, '1, 16'h0000);
    frame_at(32'd15000, '1, 16'hFFFF);
    frame_at(32'd7500, '1, 16'h8000);
    frame_at(32'd30000, '1, 16'hFFFF);
    frame_at(32'd299999, '1, 16'hFFFF);
    frame_at(32'd300000, '1, 16'hFFFF);
    drain();

    // drop beyond unity, with min above max and bits above the field width
    cfg_write(REG_DROP_MIN, 32'hFFFF_FFFF);
    set_cloud_cfg(32'hFFFF_FFFF, 32'd0, 32'd100, 32'd100, 32'd0, 32'd0);
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_ENABLE, 32'd1);
    cfg_write(REG_NONE, 32'd0);
    frame_at(T_BASE, $urandom, 16'hFFFF);
    frame_at(T_BASE + 32'd50, $urandom, 16'hFFFF);
    send_item(1'b0, '0, '0, '0, '0, 16'hFFFF);
    frame_at(T_BASE + 32'd100, $urandom, 16'hFFFF);
    frame_at(T_BASE + 32'd101, $urandom, 16'hFFFF);
    drain();

    // zero duration: the cloud never ends and the level is not dimmed
    set_cloud_cfg(32'd500, 32'd9000, 32'd0, 32'd0, 32'd0, 32'd0);
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_ENABLE, 32'd1);
    frame_at(T_BASE + 32'd200, $urandom, 16'hFFFF);
    frame_at(T_BASE + 32'd5_000_000, $urandom, 16'hABCD);
    drain();

    // widest durations and intervals, next fire time across the wrap
    set_cloud_cfg(32'd0, 32'd10000, 32'hFFFF_FFFF, 32'd16777215, 32'd268435455,
                  32'hFFFF_FFFF);
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_ENABLE, 32'd1);
    frame_at(32'hB000_0000, '1, 16'hFFFF);
    frame_at(32'hB100_0000, '1, 16'hFFFF);
    frame_at(32'hF800_0000, '1, 16'hFFFF);
    frame_at(32'hF900_0000, '1, 16'hFFFF);
    frame_at(32'hFFFF_FFFF, '1, 16'hFFFF);
    frame_at(32'h0800_0000, '1, 16'hFFFF);
    frame_at(32'h0880_0000, '1, 16'hFFFF);
    drain();

    uptime_ms = $urandom;

    next_phase(0);
    set_cloud_cfg(32'd3000, 32'd6000, 32'd20, 32'd300, 32'd100, 32'd800);
    cloud_frames(205, 1, 30);

    next_phase(1);
    set_cloud_cfg(32'd0, 32'd10000, 32'd1, 32'd50, 32'd0, 32'd60);
    cloud_frames(205, 1, 20);

    next_phase(2);
    set_cloud_cfg(32'd16383, 32'd16383, 32'd1000, 32'd4000, 32'd0, 32'd2000);
    cloud_frames(205, 10, 400);

    next_phase(3);
    set_cloud_cfg(32'd9000, 32'd100, 32'd40, 32'd5, 32'd30, 32'd0);
    cloud_frames(205, 1, 15);

    next_phase(4);
    cfg_write(REG_ENABLE, 32'd0);
    set_cloud_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    cloud_frames(205, 1, 50);

    next_phase(5);
    set_cloud_cfg(32'd0, 32'd10000, 32'd0, 32'd3, 32'd0, 32'd10);
    cfg_write(REG_ENABLE, 32'd1);
    cloud_frames(205, 0, 4);

    next_phase(6);
    set_cloud_cfg(32'd0, 32'd10000, 32'd100, 32'd16777215, 32'd0, 32'd1000);
    cloud_frames(205, 32'h1_0000, 32'h40_0000);

    next_phase(7);
    set_cloud_cfg($urandom_range(16383), $urandom_range(16383), $urandom_range(5000),
                  $urandom_range(5000), $urandom_range(3000), $urandom_range(3000));
    cloud_frames(205, 1, 100);

    next_phase(8);
    set_cloud_cfg(32'd3000, 32'd6000, 32'd30000, 32'd300000, 32'd300000, 32'd1800000);
    cloud_frames(205, 10000, 200000);

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("led_cloud_shadow_dimmer regression: pass");
    end else begin
      $display("led_cloud_shadow_dimmer regression: fail");
    end
    $finish;
  end

endmodule
